>>> rtl/core/gos_pkg.sv
`timescale 1ns / 1ps

package gos_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = 10;
  localparam int VCNT_W       = 11;
  localparam int MAX_GROUP    = 8;
  localparam int GIDX_W       = 3;
  localparam int GCNT_W       = 4;
  localparam int COORD_W      = 32;
  localparam int MAT_W        = 32;
  localparam int MAT_ENTRIES  = 9;
  localparam int MAT_DEPTH    = MAX_GROUP * MAT_ENTRIES;
  localparam int MAT_AW       = 7;
  localparam int MAP_AW       = GIDX_W + VIDX_W;
  localparam int PROD_W       = MAT_W + COORD_W;
  localparam int FRAC_SH      = 30;
  localparam int RND_W        = PROD_W - FRAC_SH;
  localparam int ACC_W        = RND_W + 2;
  localparam int SUM_W        = COORD_W + 4;
  localparam int DIV_W        = SUM_W - 1;
  localparam int STEP_W       = 4;
  localparam int DCNT_W       = 6;
  localparam int CFG_W        = 11;
  localparam int MV_LAST      = 11;

  typedef enum logic [2:0] {
    CMD_LD_MAT = 3'd0,
    CMD_LD_TGT = 3'd1,
    CMD_LD_INV = 3'd2,
    CMD_LD_VTX = 3'd3,
    CMD_RUN    = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic {
    CFG_GROUP_SIZE   = 1'b0,
    CFG_VERTEX_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CLR, S_VCHK, S_VDEC, S_GT, S_GV, S_GP,
    S_GM, S_DI, S_DV, S_DA, S_ST, S_SV, S_SM, S_FIN
  } state_t;

  typedef struct packed {
    logic                accept;
    logic                ld_mat;
    logic                ld_tmap;
    logic                ld_inv;
    logic                ld_vtx;
    logic                rd_issue;
    logic                out_load;
    logic                out_from_in;
    logic                out_rd;
    status_e             out_status;
    logic                sat_clr;
    logic                cov_clr;
    logic                sum_clr;
    logic                t_cap;
    logic                p_cap;
    logic                mv_issue;
    logic                mv_fin;
    logic                gather_add;
    logic                scat_wr;
    logic                use_avg;
    logic                div_init;
    logic                div_step;
    logic                avg_cap;
    logic [GCNT_W-1:0]   n;
    logic [VCNT_W-1:0]   nv;
    logic [VCNT_W-1:0]   v;
    logic [GIDX_W-1:0]   i;
    logic [STEP_W-1:0]   step;
  } ctl_cmd_t;

  typedef struct packed {
    logic cov_q;
    logic sat_seen;
  } dp_stat_t;

endpackage

>>> rtl/core/gos_channels.sv
`timescale 1ns / 1ps

interface gos_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  command;
  logic        [2:0]  element;
  logic        [3:0]  entry;
  logic signed [31:0] matrix_value;
  logic        [9:0]  vertex_index;
  logic        [9:0]  target_index;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;

  modport source (output valid, command, element, entry, matrix_value, vertex_index,
                  target_index, in_x, in_y, in_z, input ready);
  modport sink (input valid, command, element, entry, matrix_value, vertex_index,
                target_index, in_x, in_y, in_z, output ready);
endinterface

interface gos_out_if;
  logic               valid;
  logic               ready;
  logic        [9:0]  out_index;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic        [1:0]  status;

  modport source (output valid, out_index, out_x, out_y, out_z, status, input ready);
  modport sink (input valid, out_index, out_x, out_y, out_z, status, output ready);
endinterface

>>> rtl/core/gos_datapath.sv
`timescale 1ns / 1ps

module gos_datapath (
  input  logic                                clk,
  input  gos_pkg::ctl_cmd_t                   cmd,
  output gos_pkg::dp_stat_t                   stat,
  input  logic [gos_pkg::GIDX_W-1:0]          element,
  input  logic [3:0]                          entry,
  input  logic signed [gos_pkg::MAT_W-1:0]    matrix_value,
  input  logic [gos_pkg::VIDX_W-1:0]          vertex_index,
  input  logic [gos_pkg::VIDX_W-1:0]          target_index,
  input  logic signed [gos_pkg::COORD_W-1:0]  in_x,
  input  logic signed [gos_pkg::COORD_W-1:0]  in_y,
  input  logic signed [gos_pkg::COORD_W-1:0]  in_z,
  output logic [gos_pkg::VIDX_W-1:0]          out_index,
  output logic signed [gos_pkg::COORD_W-1:0]  out_x,
  output logic signed [gos_pkg::COORD_W-1:0]  out_y,
  output logic signed [gos_pkg::COORD_W-1:0]  out_z,
  output logic [1:0]                          status
);
  import gos_pkg::*;

  function automatic logic [1:0] col_of(input logic [STEP_W-1:0] k);
    case (k)
      4'd0, 4'd3, 4'd6: col_of = 2'd0;
      4'd1, 4'd4, 4'd7: col_of = 2'd1;
      default:          col_of = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] row_of(input logic [STEP_W-1:0] k);
    case (k)
      4'd0, 4'd1, 4'd2: row_of = 2'd0;
      4'd3, 4'd4, 4'd5: row_of = 2'd1;
      default:          row_of = 2'd2;
    endcase
  endfunction

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  // stores
  logic signed [COORD_W-1:0] xmem [MAX_VERTICES];
  logic signed [COORD_W-1:0] ymem [MAX_VERTICES];
  logic signed [COORD_W-1:0] zmem [MAX_VERTICES];
  logic signed [MAT_W-1:0]   tmem [MAT_DEPTH];
  logic [VIDX_W-1:0]         mapmem [MAX_GROUP * MAX_VERTICES];
  logic                      covmem [MAX_VERTICES];
  logic [GIDX_W-1:0]         inv_tab [MAX_GROUP];

  logic signed [COORD_W-1:0] vq [3];
  logic signed [COORD_W-1:0] p [3];
  logic signed [COORD_W-1:0] avg [3];
  logic signed [COORD_W-1:0] pv [3];
  logic signed [COORD_W-1:0] satv [3];
  logic signed [ACC_W-1:0]   acc [3];
  logic signed [SUM_W-1:0]   sum [3];
  logic [DIV_W-1:0]          quot [3];
  logic [GCNT_W-1:0]         rem [3];
  logic [2:0]                neg;
  logic [2:0]                sat_hit;

  logic signed [MAT_W-1:0]   m_q;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [RND_W-1:0]   rnd;
  logic [STEP_W-1:0]         k1, k2;
  logic                      v1, v2;
  logic [VIDX_W-1:0]         tq, t, t_now, vaddr, vi_l;
  logic [GIDX_W-1:0]         g;
  logic [MAT_AW-1:0]         tw_addr, tr_addr;
  logic [STEP_W-1:0]         rstep;
  logic                      sat_seen, cov_q;

  assign g       = cmd.use_avg ? cmd.i : inv_tab[cmd.i];
  assign rstep   = cmd.mv_issue ? cmd.step : '0;
  assign tw_addr = MAT_AW'({element, 3'b000}) + MAT_AW'(element) + MAT_AW'(entry);
  assign tr_addr = MAT_AW'({g, 3'b000}) + MAT_AW'(g) + MAT_AW'(rstep);
  assign t_now   = ({1'b0, tq} >= cmd.nv) ? cmd.v[VIDX_W-1:0] : tq;
  assign vaddr   = cmd.rd_issue ? vertex_index : (cmd.t_cap ? t_now : t);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pv[c] = cmd.use_avg ? avg[c] : p[c];
      if (acc[c] > SAT_HI) begin
        satv[c]    = SAT_HI[COORD_W-1:0];
        sat_hit[c] = 1'b1;
      end else if (acc[c] < SAT_LO) begin
        satv[c]    = SAT_LO[COORD_W-1:0];
        sat_hit[c] = 1'b1;
      end else begin
        satv[c]    = acc[c][COORD_W-1:0];
        sat_hit[c] = 1'b0;
      end
    end
  end

  assign prod = m_q * pv[col_of(k1)];
  assign rnd  = RND_W'((prod_r + (PROD_W'(1) <<< (FRAC_SH - 1))) >>> FRAC_SH);

  // vertex stores, one read port shared by gather and read-back
  always_ff @(posedge clk) begin
    if (cmd.ld_vtx) begin
      xmem[vertex_index] <= in_x;
      ymem[vertex_index] <= in_y;
      zmem[vertex_index] <= in_z;
    end else if (cmd.scat_wr) begin
      xmem[t] <= satv[0];
      ymem[t] <= satv[1];
      zmem[t] <= satv[2];
    end
    vq[0] <= xmem[vaddr];
    vq[1] <= ymem[vaddr];
    vq[2] <= zmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_mat) tmem[tw_addr] <= matrix_value;
    m_q <= tmem[tr_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_tmap) mapmem[{element, vertex_index}] <= target_index;
    tq <= mapmem[{cmd.i, cmd.v[VIDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_inv) inv_tab[element] <= target_index[GIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cov_clr) covmem[cmd.v[VIDX_W-1:0]] <= 1'b0;
    else if (cmd.scat_wr) covmem[t] <= 1'b1;
    cov_q <= covmem[cmd.v[VIDX_W-1:0]];
  end

  // matrix-vector pipe: fetch, multiply, round and accumulate
  always_ff @(posedge clk) begin
    k1     <= cmd.step;
    v1     <= cmd.mv_issue;
    k2     <= k1;
    v2     <= v1;
    prod_r <= prod;
    if (cmd.t_cap) t <= t_now;
    if (cmd.p_cap) p <= vq;
    if (cmd.accept) vi_l <= vertex_index;
    if (cmd.mv_issue && cmd.step == '0) begin
      for (int c = 0; c < 3; c++) acc[c] <= '0;
    end else if (v2) begin
      acc[row_of(k2)] <= acc[row_of(k2)] + ACC_W'(rnd);
    end
    if (cmd.sat_clr) sat_seen <= 1'b0;
    else if (cmd.mv_fin && (sat_hit != 3'b000)) sat_seen <= 1'b1;
  end

  // orbit sum and rounded division by group size, one quotient bit a cycle
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic [SUM_W-1:0]  mag;
      logic [GCNT_W:0]   rsh;
      logic              ge;
      mag = sum[c][SUM_W-1] ? SUM_W'(-sum[c]) : SUM_W'(sum[c]);
      rsh = {rem[c], quot[c][DIV_W-1]};
      ge  = (rsh >= {1'b0, cmd.n});
      if (cmd.sum_clr) sum[c] <= '0;
      else if (cmd.gather_add) sum[c] <= sum[c] + SUM_W'(satv[c]);
      if (cmd.div_init) begin
        neg[c]  <= sum[c][SUM_W-1];
        quot[c] <= mag[DIV_W-1:0] + DIV_W'(cmd.n[GCNT_W-1:1]);
        rem[c]  <= '0;
      end else if (cmd.div_step) begin
        rem[c]  <= ge ? GCNT_W'(rsh - {1'b0, cmd.n}) : rsh[GCNT_W-1:0];
        quot[c] <= {quot[c][DIV_W-2:0], ge};
      end
      if (cmd.avg_cap) begin
        avg[c] <= neg[c] ? (~quot[c][COORD_W-1:0] + COORD_W'(1)) : quot[c][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index <= cmd.out_from_in ? vertex_index : vi_l;
      out_x     <= cmd.out_rd ? vq[0] : '0;
      out_y     <= cmd.out_rd ? vq[1] : '0;
      out_z     <= cmd.out_rd ? vq[2] : '0;
      status    <= cmd.out_status;
    end
  end

  assign stat.cov_q    = cov_q;
  assign stat.sat_seen = sat_seen;

endmodule

>>> rtl/core/gos_ctrl.sv
`timescale 1ns / 1ps

module gos_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [gos_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   command,
  input  logic [3:0]                   entry,
  input  logic [gos_pkg::VIDX_W-1:0]   target_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gos_pkg::ctl_cmd_t            cmd,
  input  gos_pkg::dp_stat_t            stat
);
  import gos_pkg::*;

  state_t              state, state_next;
  logic [VCNT_W-1:0]   v, v_next;
  logic [GIDX_W-1:0]   i, i_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [DCNT_W-1:0]   dcnt, dcnt_next;
  logic [GCNT_W-1:0]   gs, n;
  logic [VCNT_W-1:0]   vc, nv;
  logic                out_valid_next;
  logic                last_i, last_v;

  assign n      = (gs == '0) ? GCNT_W'(1) : ((gs > GCNT_W'(MAX_GROUP)) ? GCNT_W'(MAX_GROUP) : gs);
  assign nv     = (vc > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vc;
  assign last_i = ({1'b0, i} == n - GCNT_W'(1));
  assign last_v = (v + VCNT_W'(1) == nv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      v         <= '0;
      i         <= '0;
      step      <= '0;
      dcnt      <= '0;
      gs        <= GCNT_W'(1);
      vc        <= VCNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      v         <= v_next;
      i         <= i_next;
      step      <= step_next;
      dcnt      <= dcnt_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        case (cfg_idx_e'(cfg_index))
          CFG_GROUP_SIZE:   gs <= cfg_data[GCNT_W-1:0];
          CFG_VERTEX_COUNT: vc <= cfg_data;
          default:          ;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    v_next     = v;
    i_next     = i;
    step_next  = step;
    dcnt_next  = dcnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.n      = n;
    cmd.nv     = nv;
    cmd.v      = v;
    cmd.i      = i;
    cmd.step   = step;
    cmd.out_status = ST_OK;

    case (state)
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          cmd.accept      = 1'b1;
          cmd.out_load    = 1'b1;
          cmd.out_from_in = 1'b1;
          case (cmd_e'(command))
            CMD_LD_MAT: begin
              if (entry >= 4'(MAT_ENTRIES)) cmd.out_status = ST_RANGE;
              else cmd.ld_mat = 1'b1;
            end
            CMD_LD_TGT: cmd.ld_tmap = 1'b1;
            CMD_LD_INV: begin
              if (target_index >= VIDX_W'(MAX_GROUP)) cmd.out_status = ST_RANGE;
              else cmd.ld_inv = 1'b1;
            end
            CMD_LD_VTX: cmd.ld_vtx = 1'b1;
            CMD_RUN: begin
              cmd.out_load = 1'b0;
              cmd.sat_clr  = 1'b1;
              v_next       = '0;
              state_next   = S_CLR;
            end
            CMD_READ: begin
              cmd.out_load = 1'b0;
              cmd.rd_issue = 1'b1;
              state_next   = S_READ;
            end
            default: cmd.out_status = ST_RANGE;
          endcase
        end
      end
      S_READ: begin
        cmd.out_load = 1'b1;
        cmd.out_rd   = 1'b1;
        state_next   = S_IDLE;
      end
      S_CLR: begin
        cmd.cov_clr = 1'b1;
        if (v[VIDX_W-1:0] == VIDX_W'(MAX_VERTICES - 1)) begin
          v_next     = '0;
          state_next = (nv == '0) ? S_FIN : S_VCHK;
        end else begin
          v_next = v + VCNT_W'(1);
        end
      end
      S_VCHK: state_next = S_VDEC;
      S_VDEC: begin
        if (stat.cov_q) begin
          if (last_v) state_next = S_FIN;
          else begin
            v_next     = v + VCNT_W'(1);
            state_next = S_VCHK;
          end
        end else begin
          cmd.sum_clr = 1'b1;
          i_next      = '0;
          state_next  = S_GT;
        end
      end
      S_GT: state_next = S_GV;
      S_GV: begin
        cmd.t_cap  = 1'b1;
        state_next = S_GP;
      end
      S_GP: begin
        cmd.p_cap  = 1'b1;
        step_next  = '0;
        state_next = S_GM;
      end
      S_GM: begin
        cmd.mv_issue = (step < STEP_W'(MAT_ENTRIES));
        if (step == STEP_W'(MV_LAST)) begin
          cmd.mv_fin     = 1'b1;
          cmd.gather_add = 1'b1;
          step_next      = '0;
          if (last_i) state_next = S_DI;
          else begin
            i_next     = i + GIDX_W'(1);
            state_next = S_GT;
          end
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_DI: begin
        cmd.div_init = 1'b1;
        dcnt_next    = '0;
        state_next   = S_DV;
      end
      S_DV: begin
        cmd.div_step = 1'b1;
        if (dcnt == DCNT_W'(DIV_W - 1)) state_next = S_DA;
        else dcnt_next = dcnt + DCNT_W'(1);
      end
      S_DA: begin
        cmd.avg_cap = 1'b1;
        i_next      = '0;
        state_next  = S_ST;
      end
      S_ST: begin
        cmd.use_avg = 1'b1;
        state_next  = S_SV;
      end
      S_SV: begin
        cmd.use_avg = 1'b1;
        cmd.t_cap   = 1'b1;
        step_next   = '0;
        state_next  = S_SM;
      end
      S_SM: begin
        cmd.use_avg  = 1'b1;
        cmd.mv_issue = (step < STEP_W'(MAT_ENTRIES));
        if (step == STEP_W'(MV_LAST)) begin
          cmd.mv_fin  = 1'b1;
          cmd.scat_wr = 1'b1;
          step_next   = '0;
          if (!last_i) begin
            i_next     = i + GIDX_W'(1);
            state_next = S_ST;
          end else if (last_v) begin
            state_next = S_FIN;
          end else begin
            v_next     = v + VCNT_W'(1);
            state_next = S_VCHK;
          end
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_FIN: begin
        cmd.out_load   = 1'b1;
        cmd.out_status = stat.sat_seen ? ST_SAT : ST_OK;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    out_valid_next = (out_valid && !out_ready) || cmd.out_load;
  end

endmodule

>>> rtl/core/group_orbit_symmetrizer.sv
`timescale 1ns / 1ps
// Load and error items give their result in the cycle after transfer; a read passes the
//   vertex store read register and S_READ. Throughput: loads 1 item/cycle while the result
//   slot is free or being taken; a read blocks the input until its result is loaded.
// Run: a mark clearing pass over all 1024 entries, then each uncovered vertex has its orbit
//   gathered, averaged and scattered; each 3x3 product walks the single transform port.
// Reset (rst, sync, high): controller idle, result slot empty, group size and vertex count 1.
module group_orbit_symmetrizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gos_pkg::CFG_W-1:0]  cfg_data,
  gos_in_if.sink                     in_ch,
  gos_out_if.source                  out_ch
);
  import gos_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // Controller: walks vertices, orbit elements, matrix steps and the divider
  gos_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .command      (in_ch.command),
    .entry        (in_ch.entry),
    .target_index (in_ch.target_index),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .cmd          (ctl_cmd),
    .stat         (dp_stat)
  );

  // Datapath: stores, multiply/round pipe, orbit sum, divider, result register
  gos_datapath u_dp (
    .clk          (clk),
    .cmd          (ctl_cmd),
    .stat         (dp_stat),
    .element      (in_ch.element),
    .entry        (in_ch.entry),
    .matrix_value (in_ch.matrix_value),
    .vertex_index (in_ch.vertex_index),
    .target_index (in_ch.target_index),
    .in_x         (in_ch.in_x),
    .in_y         (in_ch.in_y),
    .in_z         (in_ch.in_z),
    .out_index    (out_ch.out_index),
    .out_x        (out_ch.out_x),
    .out_y        (out_ch.out_y),
    .out_z        (out_ch.out_z),
    .status       (out_ch.status)
  );

  // a result is never loaded over one still waiting for transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // a run locks out further input in the following cycle
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.command == CMD_RUN) |=> !in_ch.ready)
    else $error("input taken during run");

  // a vertex load gives its result in the next cycle
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.command == CMD_LD_VTX) |=> out_ch.valid)
    else $error("load result missing");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gos_pkg::*;

  // command codes outside the decoded set
  localparam logic [2:0] CMD_BAD_A = 3'd6;
  localparam logic [2:0] CMD_BAD_B = 3'd7;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  el;
    logic [3:0]  en;
    logic [31:0] mv;
    logic [9:0]  vi;
    logic [9:0]  ti;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } gos_item_t;

  typedef struct {
    logic [9:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  st;
  } gos_res_t;

  // directed row: item plus an optional typed-in result
  typedef struct {
    gos_item_t it;
    bit        typed;
    gos_res_t  res;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  gos_in_if  in_ch ();
  gos_out_if out_ch ();

  group_orbit_symmetrizer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the block's stores and registers
  // ---------------------------------------------------------------------------
  longint vx [MAX_VERTICES];
  longint vy [MAX_VERTICES];
  longint vz [MAX_VERTICES];
  longint mat [MAT_DEPTH];
  int     tmap [MAX_GROUP*MAX_VERTICES];
  int     inv_el [MAX_GROUP];
  bit     covered [MAX_VERTICES];
  bit     sat_flag;
  int     grp_reg;
  int     cnt_reg;

  // bookkeeping so that no never-written entry is ever read
  bit     vtx_written [MAX_VERTICES];
  int     vtx_list [$];
  bit     tgt_written [MAX_GROUP*MAX_VERTICES];

  gos_res_t pending_results [$];
  int  errors;
  bit  calm;        // no idling on either side
  bit  hold_req;    // asks the receiver for a long hold-off

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Q2.30 x Q16.16 -> Q16.16, round half up
  function automatic longint q_mul(longint m, longint c);
    longint p;
    p = m * c;
    return (p + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void xform(int g, longint p0, longint p1, longint p2,
                                output longint r0, output longint r1, output longint r2);
    int b;
    b = g * 9;
    r0 = sat32(q_mul(mat[b],   p0) + q_mul(mat[b+1], p1) + q_mul(mat[b+2], p2));
    r1 = sat32(q_mul(mat[b+3], p0) + q_mul(mat[b+4], p1) + q_mul(mat[b+5], p2));
    r2 = sat32(q_mul(mat[b+6], p0) + q_mul(mat[b+7], p1) + q_mul(mat[b+8], p2));
  endfunction

  // nearest, ties away from zero
  function automatic longint avg_round(longint s, int n);
    longint mag, q;
    mag = (s < 0) ? -s : s;
    q = (mag + n / 2) / n;
    return (s < 0) ? -q : q;
  endfunction

  function automatic int grp_eff();
    return (grp_reg < 1) ? 1 : (grp_reg > MAX_GROUP) ? MAX_GROUP : grp_reg;
  endfunction

  function automatic int cnt_eff();
    return (cnt_reg > MAX_VERTICES) ? MAX_VERTICES : cnt_reg;
  endfunction

  function automatic int orbit_target(int i, int v, int nv);
    int t;
    t = tmap[i*MAX_VERTICES + v];
    return (t >= nv) ? v : t;   // stale target falls back to the source vertex
  endfunction

  function automatic void symmetrize();
    int n, nv, t;
    longint s0, s1, s2, a0, a1, a2, r0, r1, r2;
    n  = grp_eff();
    nv = cnt_eff();
    foreach (covered[k]) covered[k] = 1'b0;
    for (int v = 0; v < nv; v++) begin
      if (!covered[v]) begin
        s0 = 0; s1 = 0; s2 = 0;
        for (int i = 0; i < n; i++) begin
          t = orbit_target(i, v, nv);
          xform(inv_el[i], vx[t], vy[t], vz[t], r0, r1, r2);
          s0 += r0; s1 += r1; s2 += r2;
        end
        a0 = avg_round(s0, n);
        a1 = avg_round(s1, n);
        a2 = avg_round(s2, n);
        for (int i = 0; i < n; i++) begin
          t = orbit_target(i, v, nv);
          xform(i, a0, a1, a2, r0, r1, r2);
          vx[t] = r0; vy[t] = r1; vz[t] = r2;
          covered[t] = 1'b1;
        end
      end
    end
  endfunction

  // one transfer in, one result out; updates the predicted stores
  function automatic gos_res_t symmetrize_step(gos_item_t it);
    gos_res_t r;
    r.idx = it.vi;
    r.x = '0; r.y = '0; r.z = '0;
    r.st = ST_OK;
    case (it.cmd)
      CMD_LD_MAT: begin
        if (it.en > 8) r.st = ST_RANGE;
        else mat[it.el*9 + it.en] = longint'($signed(it.mv));
      end
      CMD_LD_TGT: begin
        tmap[it.el*MAX_VERTICES + it.vi] = it.ti;
        tgt_written[it.el*MAX_VERTICES + it.vi] = 1'b1;
      end
      CMD_LD_INV: begin
        if (it.ti >= MAX_GROUP) r.st = ST_RANGE;
        else inv_el[it.el] = it.ti;
      end
      CMD_LD_VTX: begin
        vx[it.vi] = longint'($signed(it.x));
        vy[it.vi] = longint'($signed(it.y));
        vz[it.vi] = longint'($signed(it.z));
        if (!vtx_written[it.vi]) vtx_list.push_back(it.vi);
        vtx_written[it.vi] = 1'b1;
      end
      CMD_RUN: begin
        sat_flag = 1'b0;
        symmetrize();
        r.st = sat_flag ? ST_SAT : ST_OK;
      end
      CMD_READ: begin
        r.x = vx[it.vi][31:0];
        r.y = vy[it.vi][31:0];
        r.z = vz[it.vi][31:0];
      end
      default: r.st = ST_RANGE;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, configuration
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // park the input channel and let the block drain before touching registers
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(int n, int nv);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GROUP_SIZE;
    cfg_data  <= CFG_W'(n);
    @(posedge clk);
    cfg_index <= CFG_VERTEX_COUNT;
    cfg_data  <= CFG_W'(nv);
    @(posedge clk);
    cfg_we    <= 1'b0;
    grp_reg = n & 4'hF;
    cnt_reg = nv & 11'h7FF;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: valid stays high after a transfer so back-to-back items need no
  // second assignment in one step; wait_idle lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_item(gos_item_t it, bit typed = 1'b0, gos_res_t typed_res = '{default:0});
    bit ok;
    gos_res_t r;
    while (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= it.cmd;
    in_ch.element      <= it.el;
    in_ch.entry        <= it.en;
    in_ch.matrix_value <= it.mv;
    in_ch.vertex_index <= it.vi;
    in_ch.target_index <= it.ti;
    in_ch.in_x         <= it.x;
    in_ch.in_y         <= it.y;
    in_ch.in_z         <= it.z;
    do begin
      @(negedge clk);
      ok = in_ch.ready;
      @(posedge clk);
    end while (!ok);
    r = symmetrize_step(it);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  function automatic gos_item_t blank_item(logic [2:0] cmd);
    gos_item_t it;
    it.cmd = cmd;
    it.el = 3'($urandom);  it.en = 4'($urandom);  it.mv = $urandom;
    it.vi = 10'($urandom); it.ti = 10'($urandom);
    it.x = $urandom;       it.y = $urandom;       it.z = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 32'($signed($urandom_range(33554431)) - 33554432 / 2);
    if (r < 90) return 32'h8000_0000;
    if (r < 95) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_matrix();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 32'h0;
    if (r < 30) return 32'(ONE_Q30);
    if (r < 40) return 32'(-ONE_Q30);
    if (r < 85) return 32'($signed($urandom_range(2 * 1073741823)) - 1073741823);
    return $urandom;
  endfunction

  function automatic logic [9:0] rand_target(int v, int nv);
    int r;
    r = $urandom_range(99);
    if (nv == 0 || nv >= MAX_VERTICES) return 10'($urandom_range(MAX_VERTICES - 1));
    if (r < 25) return 10'(v);
    if (r < 35) return 10'($urandom_range(MAX_VERTICES - 1, nv));   // stale
    return 10'($urandom_range(nv - 1));
  endfunction

  function automatic logic [9:0] rand_vertex(int nv);
    if (nv > 0 && $urandom_range(9) != 0) return 10'($urandom_range(nv - 1));
    return 10'($urandom);
  endfunction

  function automatic gos_item_t rand_item();
    gos_item_t it;
    int r, nv;
    nv = cnt_eff();
    r  = $urandom_range(999);
    if (r < 30) begin
      it = blank_item(CMD_RUN);
    end else if (r < 300) begin
      it = blank_item(CMD_READ);
      it.vi = 10'(vtx_list[$urandom_range(vtx_list.size() - 1)]);
    end else if (r < 550) begin
      it = blank_item(CMD_LD_VTX);
      it.vi = rand_vertex(nv);
      it.x = rand_coord(); it.y = rand_coord(); it.z = rand_coord();
    end else if (r < 700) begin
      it = blank_item(CMD_LD_TGT);
      it.vi = rand_vertex(nv);
      it.ti = rand_target(it.vi, nv);
    end else if (r < 800) begin
      it = blank_item(CMD_LD_MAT);
      it.en = 4'($urandom_range(8));
      it.mv = rand_matrix();
    end else if (r < 880) begin
      it = blank_item(CMD_LD_INV);
      it.ti = 10'($urandom_range(MAX_GROUP - 1));
    end else if (r < 910) begin
      it = blank_item(CMD_LD_MAT);
      it.en = 4'($urandom_range(15, 9));
    end else if (r < 940) begin
      it = blank_item(CMD_LD_INV);
      it.ti = 10'($urandom_range(MAX_VERTICES - 1, MAX_GROUP));
    end else begin
      it = blank_item(($urandom_range(1) != 0) ? CMD_BAD_A : CMD_BAD_B);
    end
    return it;
  endfunction

  // fill every store that a run with the current registers will read
  task automatic load_group_data();
    gos_item_t it;
    int n, nv;
    n  = grp_eff();
    nv = cnt_eff();
    for (int e = 0; e < MAX_GROUP; e++) begin
      for (int k = 0; k < MAT_ENTRIES; k++) begin
        it = blank_item(CMD_LD_MAT);
        it.el = 3'(e); it.en = 4'(k); it.mv = rand_matrix();
        send_item(it);
      end
      it = blank_item(CMD_LD_INV);
      it.el = 3'(e); it.ti = 10'($urandom_range(MAX_GROUP - 1));
      send_item(it);
    end
    for (int i = 0; i < n; i++)
      for (int v = 0; v < nv; v++)
        if (nv <= 64 || !tgt_written[i*MAX_VERTICES + v]) begin
          it = blank_item(CMD_LD_TGT);
          it.el = 3'(i); it.vi = 10'(v); it.ti = rand_target(v, nv);
          send_item(it);
        end
    for (int v = 0; v < nv; v++)
      if (nv <= 64 || !vtx_written[v]) begin
        it = blank_item(CMD_LD_VTX);
        it.vi = 10'(v);
        it.x = rand_coord(); it.y = rand_coord(); it.z = rand_coord();
        send_item(it);
      end
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows, run with the reset settings (one element, one vertex)
  // ---------------------------------------------------------------------------
  function automatic dir_row_t mk_row(logic [2:0] cmd, logic [2:0] el, logic [3:0] en,
                                      logic [31:0] mv, logic [9:0] vi, logic [9:0] ti,
                                      logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      bit typed, logic [1:0] st,
                                      logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
    dir_row_t d;
    d.it = '{cmd, el, en, mv, vi, ti, x, y, z};
    d.typed = typed;
    d.res = '{vi, ex, ey, ez, st};
    return d;
  endfunction

  dir_row_t dir_rows [$];

  task automatic build_directed();
    // matrix for element 0: extremes at both ends of the diagonal, one in the middle, zero elsewhere
    dir_rows.push_back(mk_row(CMD_LD_MAT, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    for (int k = 1; k < 8; k++)
      dir_rows.push_back(mk_row(CMD_LD_MAT, 0, 4'(k), (k == 4) ? 32'h4000_0000 : 32'h0,
                                10'(k), 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LD_MAT, 0, 8, 32'h8000_0000, 8, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    // entry index out of range
    dir_rows.push_back(mk_row(CMD_LD_MAT, 7, 9, 32'hFFFF_FFFF, 1023, 0, 0, 0, 0,
                              1, ST_RANGE, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LD_MAT, 3, 15, 32'h1234_5678, 3, 0, 0, 0, 0,
                              1, ST_RANGE, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LD_INV, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    // inverse index beyond the group
    dir_rows.push_back(mk_row(CMD_LD_INV, 0, 0, 0, 5, 1023, 0, 0, 0, 1, ST_RANGE, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LD_TGT, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LD_TGT, 7, 0, 0, 1023, 1023, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LD_VTX, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h0001_2345, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_2345));
    // unknown commands leave everything alone
    dir_rows.push_back(mk_row(CMD_BAD_A, 5, 6, 32'hFFFF_FFFF, 1023, 1023, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_RANGE, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_BAD_B, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_RANGE, 0, 0, 0));
    // run saturates on the extreme diagonal; then read back the result
    dir_rows.push_back(mk_row(CMD_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int phase_grp [10] = '{1, 8, 0, 15, 3, 5, 2, 8, 1, 1};
  int phase_cnt [10] = '{1, 16, 5, 9, 2, 12, 0, 1, 40, 24};

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_GROUP_SIZE;
    cfg_data  <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_LD_MAT;
    in_ch.element      <= '0;
    in_ch.entry        <= '0;
    in_ch.matrix_value <= '0;
    in_ch.vertex_index <= '0;
    in_ch.target_index <= '0;
    in_ch.in_x         <= '0;
    in_ch.in_y         <= '0;
    in_ch.in_z         <= '0;
    errors   = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    grp_reg  = 1;
    cnt_reg  = 1;
    sat_flag = 1'b0;
    foreach (vx[k]) begin
      vx[k] = 0; vy[k] = 0; vz[k] = 0; covered[k] = 1'b0; vtx_written[k] = 1'b0;
    end
    foreach (mat[k]) mat[k] = 0;
    foreach (tmap[k]) begin
      tmap[k] = 0; tgt_written[k] = 1'b0;
    end
    foreach (inv_el[k]) inv_el[k] = 0;
    build_directed();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);

    for (int ph = 0; ph < 10; ph++) begin
      write_config(phase_grp[ph], phase_cnt[ph]);
      calm = (ph == 2);   // one phase runs flat out on both sides
      load_group_data();
      send_item(blank_item(CMD_RUN));
      if (ph == 1) hold_req = 1'b1;  // receiver stops while items keep coming
      repeat ((ph < 8) ? 80 : 20) send_item(rand_item());
    end
    calm = 1'b0;

    wait_idle();
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // Checker: fields are stable by the falling edge; the transfer completes at
  // the next rising edge.
  always @(negedge clk) begin
    gos_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result idx=%0d x=%h y=%h z=%h st=%0d", $time,
                 out_ch.out_index, out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.out_index !== e.idx) begin
          $display("%0t: out_index expected %0d actual %0d", $time, e.idx, out_ch.out_index);
          errors++;
        end
        if (out_ch.out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_ch.out_x);
          errors++;
        end
        if (out_ch.out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_ch.out_y);
          errors++;
        end
        if (out_ch.out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_ch.out_z);
          errors++;
        end
        if (out_ch.status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_ch.status);
          errors++;
        end
      end
    end
  end

endmodule

>>> sim.f
rtl/core/gos_pkg.sv
rtl/core/gos_channels.sv
rtl/core/gos_datapath.sv
rtl/core/gos_ctrl.sv
rtl/core/group_orbit_symmetrizer.sv
test/tb_top.sv
